// ----- design/utf16_to_utf8_transcoder_defines.svh -----
// assertion macros shared by the transcoder modules
// no dependencies; included by files that carry concurrent checks
`ifndef UTF16_TO_UTF8_TRANSCODER_DEFINES_SVH
`define UTF16_TO_UTF8_TRANSCODER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define U16U8_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u16u8 check failed");

// next-cycle implication, disabled while in reset
`define U16U8_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u16u8 check failed");

`endif

// ----- design/u16u8_pkg.sv -----
// types, constants and encode helpers for the utf-16 to utf-8 transcoder
// no dependencies; used by every module of the block
package u16u8_pkg;

    localparam int unsigned UNIT_W        = 21;
    localparam int unsigned JOB_DEPTH_DEF = 2;

    // upper bits of a unit that mark a high or low surrogate
    localparam logic [10:0] HIGH_SURR_TAG = 11'b00000110110;
    localparam logic [10:0] LOW_SURR_TAG  = 11'b00000110111;
    localparam logic [5:0]  HIGH_PREFIX   = 6'b110110;

    // utf-8 lead and continuation marks
    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [7:0] CONT  = 8'h80;

    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_ONE  = 3'd1;
    localparam logic [2:0] LEN_TWO  = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR = 3'd4;

    // one unit of work for the back end: optional flushed high surrogate,
    // then a code point of len1 bytes
    typedef struct packed {
        logic                cp0_valid;
        logic [9:0]          hi_bits;
        logic [UNIT_W-1:0]   cp1;
        logic [2:0]          len1;
    } job_t;

    // number of utf-8 bytes for a code point, zero when out of range
    function automatic logic [2:0] enc_len(input logic [UNIT_W-1:0] cp);
        logic [2:0] len;
        if (cp < 21'h80)
            len = LEN_ONE;
        else if (cp < 21'h800)
            len = LEN_TWO;
        else if (cp < 21'h10000)
            len = LEN_THREE;
        else if (cp < 21'h110000)
            len = LEN_FOUR;
        else
            len = LEN_NONE;
        return len;
    endfunction

    // byte idx of the encoding of cp in len bytes
    function automatic logic [7:0] enc_byte(input logic [UNIT_W-1:0] cp,
                                            input logic [2:0] len,
                                            input logic [1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (len)
            LEN_ONE:
                b = cp[7:0];
            LEN_TWO:
                case (idx)
                    2'd0:    b = LEAD2 | {3'b000, cp[10:6]};
                    default: b = CONT | {2'b00, cp[5:0]};
                endcase
            LEN_THREE:
                case (idx)
                    2'd0:    b = LEAD3 | {4'b0000, cp[15:12]};
                    2'd1:    b = CONT | {2'b00, cp[11:6]};
                    default: b = CONT | {2'b00, cp[5:0]};
                endcase
            LEN_FOUR:
                case (idx)
                    2'd0:    b = LEAD4 | {5'b00000, cp[20:18]};
                    2'd1:    b = CONT | {2'b00, cp[17:12]};
                    2'd2:    b = CONT | {2'b00, cp[11:6]};
                    default: b = CONT | {2'b00, cp[5:0]};
                endcase
            default:
                b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ----- design/u16u8_front.sv -----
// front end: accepts code units, tracks the held high surrogate, builds jobs
// depends on u16u8_pkg and the assertion macro header
`include "utf16_to_utf8_transcoder_defines.svh"

module u16u8_front
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  logic [u16u8_pkg::UNIT_W-1:0]     code_unit,
    input  logic                             final_unit,
    output logic                             job_push,
    output u16u8_pkg::job_t                  job
);
    import u16u8_pkg::*;

    logic       held_valid_reg;
    logic       held_valid_next;
    logic [9:0] held_bits_reg;
    logic [9:0] held_bits_next;
    logic       is_high;
    logic       is_low;
    logic       pair;
    logic [2:0] unit_len;

    // classify the incoming unit
    assign is_high  = (code_unit[UNIT_W-1:10] == HIGH_SURR_TAG);
    assign is_low   = (code_unit[UNIT_W-1:10] == LOW_SURR_TAG);
    assign pair     = held_valid_reg && is_low;
    assign unit_len = enc_len(code_unit);

    // build the job and the next held state
    always_comb
    begin
        job.hi_bits     = held_bits_reg;
        job.cp0_valid   = 1'b0;
        job.cp1         = code_unit;
        job.len1        = unit_len;
        held_valid_next = held_valid_reg;
        held_bits_next  = held_bits_reg;
        if (accept)
        begin
            if (pair)
            begin
                job.cp1         = 21'h10000 + {1'b0, held_bits_reg, code_unit[9:0]};
                job.len1        = LEN_FOUR;
                held_valid_next = 1'b0;
            end
            else
            begin
                job.cp0_valid = held_valid_reg && (unit_len != LEN_FOUR);
                if (is_high && !final_unit)
                begin
                    job.len1        = LEN_NONE;
                    held_valid_next = 1'b1;
                    held_bits_next  = code_unit[9:0];
                end
                else
                begin
                    held_valid_next = 1'b0;
                end
            end
        end
    end

    assign job_push = accept && (job.cp0_valid || (job.len1 != LEN_NONE));

    // held surrogate state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            held_bits_reg  <= 10'd0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            held_bits_reg  <= held_bits_next;
        end
    end

    `U16U8_ASSERT_NEXT(a_pair_clears_hold, clk, rst_n, accept && pair, !held_valid_reg)
    `U16U8_ASSERT_NOW(a_pair_is_four, clk, rst_n, accept && pair,
        job_push && !job.cp0_valid && (job.len1 == LEN_FOUR))

endmodule

// ----- design/u16u8_job_fifo.sv -----
// short job queue between the front and back ends, flip-flop storage
// depends on u16u8_pkg and the assertion macro header
`include "utf16_to_utf8_transcoder_defines.svh"

module u16u8_job_fifo
#(
    parameter int unsigned DEPTH = u16u8_pkg::JOB_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  u16u8_pkg::job_t  wr_data,
    input  logic             rd_en,
    output u16u8_pkg::job_t  rd_data,
    output logic             full,
    output logic             empty
);
    import u16u8_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    job_t          store_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_wr;
    logic          do_rd;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = store_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            store_reg[wr_ptr_reg] <= wr_data;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + CW'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - CW'(1);
        end
    end

    `U16U8_ASSERT_NEXT(a_fill_up, clk, rst_n, do_wr && !do_rd,
        count_reg == $past(count_reg) + CW'(1))
    `U16U8_ASSERT_NEXT(a_fill_down, clk, rst_n, do_rd && !do_wr,
        count_reg == $past(count_reg) - CW'(1))

endmodule

// ----- design/u16u8_back.sv -----
// back end: walks a job one byte a cycle into the result register while it is empty or popped
// depends on u16u8_pkg and the assertion macro header
`include "utf16_to_utf8_transcoder_defines.svh"

module u16u8_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    input  u16u8_pkg::job_t  job,
    output logic             job_pop,
    input  logic             pop,
    output logic             empty,
    output logic [7:0]       utf8_byte,
    output logic             run_last
);
    import u16u8_pkg::*;

    logic [2:0]        idx_reg;
    logic [2:0]        idx_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        byte_reg;
    logic              last_reg;
    logic [2:0]        len0;
    logic [2:0]        total;
    logic [2:0]        idx1;
    logic [UNIT_W-1:0] cp0;
    logic [7:0]        byte_now;
    logic              last_now;
    logic              advance;

    // byte selection within the job
    assign len0     = job.cp0_valid ? LEN_THREE : LEN_NONE;
    assign total    = len0 + job.len1;
    assign idx1     = idx_reg - len0;
    assign cp0      = {5'd0, HIGH_PREFIX, job.hi_bits};
    assign byte_now = (idx_reg < len0) ? enc_byte(cp0, LEN_THREE, idx_reg[1:0])
                                       : enc_byte(job.cp1, job.len1, idx1[1:0]);
    assign last_now = (idx_reg == total - 3'd1);

    assign advance  = job_valid && (!out_valid_reg || pop);
    assign job_pop  = advance && last_now;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            idx_next       = last_now ? 3'd0 : idx_reg + 3'd1;
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byte_reg <= byte_now;
            last_reg <= last_now;
        end
    end

    assign empty     = !out_valid_reg;
    assign utf8_byte = byte_reg;
    assign run_last  = last_reg;

    `U16U8_ASSERT_NOW(a_idx_in_job, clk, rst_n, job_valid, idx_reg < total)
    `U16U8_ASSERT_NEXT(a_pop_marks_last, clk, rst_n, job_pop, out_valid_reg && last_reg)

endmodule

// ----- design/utf16_to_utf8_transcoder.sv -----
// utf-16 to utf-8 transcoder: one unit in, zero to six bytes out a byte a cycle while the result is popped
// path: a taken unit's job is written to the job queue before the back end registers its first byte
// throughput: one unit a cycle in while the job queue has room, one byte a cycle out
//   while the result is popped or empty; a held high surrogate is paired with the next
//   unit, flushed ahead of it, or dropped when that unit needs four bytes
// reset: asynchronous, active low; clears the held surrogate, job queue and result
module utf16_to_utf8_transcoder
#(
    parameter int unsigned JOB_DEPTH = u16u8_pkg::JOB_DEPTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [u16u8_pkg::UNIT_W-1:0]  code_unit,
    input  logic                          final_unit,
    output logic                          empty,
    input  logic                          pop,
    output logic [7:0]                    utf8_byte,
    output logic                          run_last
);
    import u16u8_pkg::*;

    job_t job_in;
    job_t job_out;
    logic job_push;
    logic job_pop;
    logic fifo_full;
    logic fifo_empty;
    logic accept;

    // input transaction
    assign full   = fifo_full;
    assign accept = push && !fifo_full;

    u16u8_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .code_unit  (code_unit),
        .final_unit (final_unit),
        .job_push   (job_push),
        .job        (job_in)
    );

    u16u8_job_fifo #(.DEPTH(JOB_DEPTH)) u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .rd_en   (job_pop),
        .rd_data (job_out),
        .full    (fifo_full),
        .empty   (fifo_empty)
    );

    u16u8_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!fifo_empty),
        .job       (job_out),
        .job_pop   (job_pop),
        .pop       (pop),
        .empty     (empty),
        .utf8_byte (utf8_byte),
        .run_last  (run_last)
    );

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for the utf-16 to utf-8 transcoder: directed and random unit streams
// predicts every output byte from its own surrogate tracking and compares each popped transaction
// depends on u16u8_pkg and utf16_to_utf8_transcoder
module tb_top;

    import u16u8_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 16;

    // one expected output byte
    typedef struct {
        logic [7:0] data;
        logic       last;
    } utf8_exp_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    logic [UNIT_W-1:0] code_unit = '0;
    logic              final_unit = 1'b0;
    logic              empty;
    logic              pop = 1'b0;
    logic [7:0]        utf8_byte;
    logic              run_last;

    utf8_exp_t   expected_bytes[$];
    logic [7:0]  unit_bytes[$];
    logic        held_valid = 1'b0;
    logic [9:0]  held_bits = '0;
    int          push_idle_pct = 0;
    int          pop_idle_pct = 0;
    int          fail_count = 0;
    int          stall_cycles = 0;

    utf16_to_utf8_transcoder i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .code_unit  (code_unit),
        .final_unit (final_unit),
        .empty      (empty),
        .pop        (pop),
        .utf8_byte  (utf8_byte),
        .run_last   (run_last)
    );

    // clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // number of utf-8 bytes a code point needs, zero when out of range
    function automatic int utf8_length(input logic [UNIT_W-1:0] cp);
        if (cp < 21'h80)
            return 1;
        else if (cp < 21'h800)
            return 2;
        else if (cp < 21'h10000)
            return 3;
        else if (cp < 21'h110000)
            return 4;
        return 0;
    endfunction

    // append the utf-8 encoding of one code point to the bytes of this unit
    function automatic void encode_code_point(input logic [UNIT_W-1:0] cp);
        case (utf8_length(cp))
            1:
                unit_bytes.push_back(cp[7:0]);
            2:
            begin
                unit_bytes.push_back(LEAD2 | {3'b000, cp[10:6]});
                unit_bytes.push_back(CONT | {2'b00, cp[5:0]});
            end
            3:
            begin
                unit_bytes.push_back(LEAD3 | {4'b0000, cp[15:12]});
                unit_bytes.push_back(CONT | {2'b00, cp[11:6]});
                unit_bytes.push_back(CONT | {2'b00, cp[5:0]});
            end
            4:
            begin
                unit_bytes.push_back(LEAD4 | {5'b00000, cp[20:18]});
                unit_bytes.push_back(CONT | {2'b00, cp[17:12]});
                unit_bytes.push_back(CONT | {2'b00, cp[11:6]});
                unit_bytes.push_back(CONT | {2'b00, cp[5:0]});
            end
            default:
                ;
        endcase
    endfunction

    // work out the bytes one accepted unit causes and queue them
    function automatic void predict_unit_bytes(input logic [UNIT_W-1:0] cu, input logic fin);
        logic      is_high;
        logic      is_low;
        utf8_exp_t entry;
        int        n;
        is_high = (cu >= 21'hD800) && (cu <= 21'hDBFF);
        is_low  = (cu >= 21'hDC00) && (cu <= 21'hDFFF);
        unit_bytes.delete();
        if (held_valid && is_low)
        begin
            // pair combines into one supplementary code point
            encode_code_point(21'h10000 + {1'b0, held_bits, 10'b0} + (cu - 21'hDC00));
            held_valid = 1'b0;
            held_bits  = '0;
        end
        else
        begin
            // flush the held high surrogate unless the current unit needs four bytes
            if (held_valid)
            begin
                if (utf8_length(cu) != 4)
                    encode_code_point({11'b00000110110, held_bits});
                held_valid = 1'b0;
                held_bits  = '0;
            end
            if (is_high && !fin)
            begin
                held_valid = 1'b1;
                held_bits  = cu[9:0];
            end
            else
                encode_code_point(cu);
        end
        n = (unit_bytes.size() > 6) ? 6 : unit_bytes.size();
        for (int k = 0; k < n; k++)
        begin
            entry.data = unit_bytes[k];
            entry.last = (k == n - 1);
            expected_bytes.push_back(entry);
        end
    endfunction

    // offer one unit and wait until the transcoder takes it
    task automatic send_unit(input logic [UNIT_W-1:0] cu, input logic fin);
        while ($urandom_range(99) < push_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        code_unit  <= cu;
        final_unit <= fin;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_unit_bytes(cu, fin);
    endtask

    // boundaries of every encoding length and out-of-range values
    task automatic test_code_point_ranges();
        send_unit(21'h000000, 1'b0);
        send_unit(21'h00007F, 1'b1);
        send_unit(21'h000080, 1'b0);
        send_unit(21'h0007FF, 1'b0);
        send_unit(21'h000800, 1'b1);
        send_unit(21'h00FFFF, 1'b0);
        send_unit(21'h010000, 1'b0);
        send_unit(21'h10FFFF, 1'b1);
        send_unit(21'h110000, 1'b0);
        send_unit(21'h1FFFFF, 1'b1);
    endtask

    // pairing, flushing and dropping of held high surrogates
    task automatic test_surrogate_cases();
        // well-formed pairs, extremes of both halves, low with and without final
        send_unit(21'h00D800, 1'b0);
        send_unit(21'h00DC00, 1'b0);
        send_unit(21'h00DBFF, 1'b0);
        send_unit(21'h00DFFF, 1'b1);
        // high surrogate as the last unit of a string
        send_unit(21'h00DA5A, 1'b1);
        // held high flushed ahead of a final high
        send_unit(21'h00D9C3, 1'b0);
        send_unit(21'h00DB01, 1'b1);
        // held high flushed ahead of plain text
        send_unit(21'h00D812, 1'b0);
        send_unit(21'h000041, 1'b0);
        // held high dropped by a supplementary code point
        send_unit(21'h00DAAA, 1'b0);
        send_unit(21'h01F600, 1'b0);
        // held high flushed ahead of an out-of-range value
        send_unit(21'h00D955, 1'b0);
        send_unit(21'h15A5A5, 1'b0);
        // lone low surrogates
        send_unit(21'h00DC00, 1'b0);
        send_unit(21'h00DFFF, 1'b1);
    endtask

    // mostly well-formed text with random content, plus broken pairs and noise
    task automatic test_random_text(input int n_units, input int idle_pct);
        int              kind;
        logic [UNIT_W-1:0] cu;
        logic            fin;
        push_idle_pct = idle_pct;
        pop_idle_pct  = idle_pct;
        for (int i = 0; i < n_units; i++)
        begin
            kind = $urandom_range(99);
            fin  = ($urandom_range(99) < 15);
            if (kind < 25)
            begin
                // surrogate pair; the high half is sometimes marked final
                send_unit(21'hD800 | UNIT_W'($urandom_range(0, 'h3FF)),
                          ($urandom_range(99) < 10));
                send_unit(21'hDC00 | UNIT_W'($urandom_range(0, 'h3FF)), fin);
            end
            else
            begin
                if (kind < 50)
                    cu = UNIT_W'($urandom_range(0, 'h7F));
                else if (kind < 62)
                    cu = UNIT_W'($urandom_range('h80, 'h7FF));
                else if (kind < 74)
                    cu = UNIT_W'($urandom_range('h800, 'hFFFF));
                else if (kind < 82)
                    cu = UNIT_W'($urandom_range('hD800, 'hDBFF));
                else if (kind < 88)
                    cu = UNIT_W'($urandom_range('hDC00, 'hDFFF));
                else if (kind < 94)
                    cu = UNIT_W'($urandom_range('h10000, 'h10FFFF));
                else
                    cu = UNIT_W'($urandom_range(0, 'h1FFFFF));
                send_unit(cu, fin);
            end
        end
    endtask

    // result side back-pressure
    always @(posedge clk)
    begin
        pop <= ($urandom_range(99) >= pop_idle_pct);
    end

    // compare each popped transaction with the oldest expected byte
    always @(posedge clk)
    begin : check_result
        utf8_exp_t oldest;
        if (rst_n && pop && !empty)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected byte: utf8_byte=%h run_last=%b", utf8_byte, run_last);
                fail_count++;
            end
            else
            begin
                oldest = expected_bytes.pop_front();
                if (utf8_byte !== oldest.data)
                begin
                    $error("utf8_byte mismatch: expected %h, actual %h", oldest.data, utf8_byte);
                    fail_count++;
                end
                if (run_last !== oldest.last)
                begin
                    $error("run_last mismatch: expected %b, actual %b", oldest.last, run_last);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("utf16_to_utf8_transcoder verification failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // test sequence
    initial
    begin
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        push_idle_pct = 27;
        pop_idle_pct  = 27;
        test_code_point_ranges();
        test_surrogate_cases();
        test_random_text(100, 27);
        // a stretch with both sides always ready
        test_random_text(40, 0);
        push <= 1'b0;
        pop_idle_pct = 27;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (fail_count == 0)
            $display("utf16_to_utf8_transcoder verification clean");
        else
            $display("utf16_to_utf8_transcoder verification failed");
        $finish;
    end

endmodule
